@@ hdl/mbb_pkg.sv @@
// Shared types and constants for the paged monochrome bitmap blitter.
// No dependencies; imported by mbb_walker, mbb_rmw and the top level.
`default_nettype none

package mbb_pkg;

  // Command codes carried in tuser bit 0
  localparam logic CMD_BLIT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] CFG_BITMAP_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_BITMAP_HEIGHT = 2'd3;

  // Bitmap size clamps
  localparam logic [7:0] MAX_BM_WIDTH  = 8'd128;
  localparam logic [6:0] MAX_BM_HEIGHT = 7'd64;

  typedef struct packed {
    logic [7:0] origin_x;       // signed
    logic [6:0] origin_y;       // signed
    logic [7:0] bitmap_width;
    logic [6:0] bitmap_height;
  } cfg_t;

  // One pixel update handed from the walker to the read-modify-write stage
  typedef struct packed {
    logic       valid;
    logic       on;
    logic [2:0] bit_idx;
  } pix_req_t;

endpackage

`default_nettype wire

@@ hdl/mbb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/mbb_walker.sv @@
// Pixel walker: shifts a bitmap byte out one pixel per cycle while step_i is high, keeps the
// column/row counters and forms the framebuffer address. Uses mbb_pkg.
`default_nettype none

module mbb_walker
  import mbb_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int AW             = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          load_i,
  input  wire logic          restart_i,
  input  wire logic [7:0]    pixel_byte_i,
  input  wire logic          step_i,
  output pix_req_t           req_o,
  output logic      [AW-1:0] addr_o,
  output logic               done_o
);

  localparam logic [8:0] PX_LIMIT = 9'(DISPLAY_WIDTH);
  localparam logic [7:0] PY_LIMIT = 8'(DISPLAY_HEIGHT);

  logic [6:0] col_q, col_d;
  logic [6:0] row_q, row_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;

  logic [7:0] w_eff;
  logic [6:0] h_eff;
  logic       active;
  logic [7:0] col_inc;
  logic       wrap;
  logic [9:0] px;
  logic [8:0] py;
  logic       in_disp;

  always_comb begin
    w_eff   = (cfg_i.bitmap_width > MAX_BM_WIDTH) ? MAX_BM_WIDTH : cfg_i.bitmap_width;
    h_eff   = (cfg_i.bitmap_height > MAX_BM_HEIGHT) ? MAX_BM_HEIGHT : cfg_i.bitmap_height;
    active  = step_i && (w_eff != 8'd0) && (h_eff != 7'd0) && (row_q < h_eff);
    col_inc = {1'b0, col_q} + 8'd1;
    wrap    = (col_inc >= w_eff);
    px      = {{2{cfg_i.origin_x[7]}}, cfg_i.origin_x} + {3'b000, col_q};
    py      = {{2{cfg_i.origin_y[6]}}, cfg_i.origin_y} + {2'b00, row_q};
    in_disp = !px[9] && (px[8:0] < PX_LIMIT) && !py[8] && (py[7:0] < PY_LIMIT);

    req_o.valid   = active && in_disp;
    req_o.on      = shift_q[7];
    req_o.bit_idx = py[2:0];
    addr_o        = AW'(32'(py[7:3]) * 32'(DISPLAY_WIDTH) + 32'(px[8:0]));
    done_o        = step_i && (bit_cnt_q == 3'd7);
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    if (load_i) begin
      shift_d   = pixel_byte_i;
      bit_cnt_d = 3'd0;
      if (restart_i) begin
        col_d = 7'd0;
        row_d = 7'd0;
      end
    end else if (step_i) begin
      shift_d   = {shift_q[6:0], 1'b0};
      bit_cnt_d = bit_cnt_q + 3'd1;
      if (active) begin
        if (wrap) begin
          col_d = 7'd0;
          row_d = row_q + 7'd1;
        end else begin
          col_d = col_inc[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= 7'd0;
      row_q     <= 7'd0;
      bit_cnt_q <= 3'd0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

`default_nettype wire

@@ hdl/mbb_rmw.sv @@
// Read-modify-write stage: merges one pixel into the byte read from the
// framebuffer, forwarding the previous write on an address match. Uses mbb_pkg.
`default_nettype none

module mbb_rmw
  import mbb_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pix_req_t      req_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    rdata_i,
  output logic               we_o,
  output logic      [AW-1:0] waddr_o,
  output logic      [7:0]    wdata_o
);

  logic          b_valid_q;
  logic          b_on_q;
  logic [2:0]    b_bit_q;
  logic [AW-1:0] b_addr_q;
  logic          fw_valid_q;
  logic [AW-1:0] fw_addr_q;
  logic [7:0]    fw_data_q;

  logic [7:0] base;
  logic [7:0] mask;

  always_comb begin
    // The RAM has not yet seen the write of the cycle before
    base    = (fw_valid_q && (fw_addr_q == b_addr_q)) ? fw_data_q : rdata_i;
    mask    = 8'h01 << b_bit_q;
    wdata_o = b_on_q ? (base | mask) : (base & ~mask);
    we_o    = b_valid_q;
    waddr_o = b_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      fw_valid_q <= 1'b0;
    end else begin
      b_valid_q  <= req_i.valid;
      fw_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_on_q    <= req_i.on;
    b_bit_q   <= req_i.bit_idx;
    b_addr_q  <= addr_i;
    fw_addr_q <= b_addr_q;
    fw_data_q <= wdata_o;
  end

endmodule

`default_nettype wire

@@ hdl/mono_bitmap_blit_paged.sv @@
// Paged monochrome bitmap blitter, top level. Blit word: accept, then one pixel
// per cycle from the walker's shift register; its last framebuffer write lands in
// the cycle after the final pixel, back in idle, where the next word can be taken.
// Read word: accept, READ, then RESP, which loads the result register once it has room.
// Blit rate is set by the one-pixel-per-cycle walk; words are taken only in idle.
// Reset: a clearing pass writes zero to each of the DISPLAY_WIDTH*ceil(DISPLAY_HEIGHT/8)
// framebuffer bytes (1024 at defaults), one per cycle, with tready held low.
// Uses mbb_pkg, mbb_ram, mbb_walker, mbb_rmw.
`default_nettype none

module mono_bitmap_blit_paged
  import mbb_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [7:0] pixel_byte, [17:8] read_address
  input  wire logic [1:0]  s_axis_tuser_i,  // [0] cmd, [1] restart
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,  // [7:0] read_data
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_BLIT  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cfg_t          cfg_q, cfg_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          rd_in_range_q, rd_in_range_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;

  logic          in_accept;
  logic          blit_load;
  logic          blit_done;
  logic          clr_last;
  logic          out_free;

  pix_req_t      pix_req;
  logic [AW-1:0] pix_addr;
  logic          rmw_we;
  logic [AW-1:0] rmw_waddr;
  logic [7:0]    rmw_wdata;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Handshakes: take a word only from idle; config is always taken
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign blit_load       = in_accept && (s_axis_tuser_i[0] == CMD_BLIT);
  assign clr_last        = (clr_cnt_q == AW'(STORE_DEPTH - 1));
  // Output register frees up in the same cycle its word is taken
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:      cfg_d.origin_x      = cfg_data_i;
        CFG_ORIGIN_Y:      cfg_d.origin_y      = cfg_data_i[6:0];
        CFG_BITMAP_WIDTH:  cfg_d.bitmap_width  = cfg_data_i;
        CFG_BITMAP_HEIGHT: cfg_d.bitmap_height = cfg_data_i[6:0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    rd_addr_d     = rd_addr_q;
    rd_in_range_d = rd_in_range_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the framebuffer, one byte per cycle
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser_i[0] == CMD_READ) begin
            rd_addr_d     = AW'(s_axis_tdata_i[17:8]);
            rd_in_range_d = (32'(s_axis_tdata_i[17:8]) < 32'(STORE_DEPTH));
            state_d       = ST_READ;
          end else begin
            state_d = ST_BLIT;
          end
        end
      end
      ST_BLIT: begin
        if (blit_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // Hold the RAM address until the output register has room
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_in_range_q ? ram_rdata : 8'h00;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM port muxing: the clearing pass owns the write port until it ends
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = rmw_we;
      ram_waddr = rmw_waddr;
      ram_wdata = rmw_wdata;
    end
    ram_raddr = ((state_q == ST_READ) || (state_q == ST_RESP)) ? rd_addr_q : pix_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= '{origin_x: 8'd0, origin_y: 7'd0,
                       bitmap_width: 8'd128, bitmap_height: 7'd64};
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q     <= rd_addr_d;
    rd_in_range_q <= rd_in_range_d;
    out_data_q    <= out_data_d;
  end

  mbb_walker #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .AW             (AW)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .load_i       (blit_load),
    .restart_i    (s_axis_tuser_i[1]),
    .pixel_byte_i (s_axis_tdata_i[7:0]),
    .step_i       (state_q == ST_BLIT),
    .req_o        (pix_req),
    .addr_o       (pix_addr),
    .done_o       (blit_done)
  );

  mbb_rmw #(
    .AW (AW)
  ) u_rmw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (pix_req),
    .addr_i  (pix_addr),
    .rdata_i (ram_rdata),
    .we_o    (rmw_we),
    .waddr_o (rmw_waddr),
    .wdata_o (rmw_wdata)
  );

  mbb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // No pixel write may collide with the clearing pass
  a_no_rmw_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !rmw_we)
    else $error("pixel write during clearing pass");

  // A new result only ever follows a read response cycle
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result without read command");

  // The walker finishing a byte returns the sequencer to idle
  a_blit_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blit_done |=> (state_q == ST_IDLE))
    else $error("blit did not return to idle");

  // Every pixel write was requested by the walker in the cycle before
  a_write_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmw_we |-> $past(pix_req.valid))
    else $error("write without pixel request");
`endif

endmodule

`default_nettype wire
